>>> sv/lecr_pkg.sv
// Shared codes, widths and helpers for the line-editing character ring.
package lecr_pkg;

   localparam int DEPTH_DEFAULT = 256;

   localparam int TYPE_W   = 3;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_PUT    = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_GET    = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_MARK   = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_ERASE  = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_WERASE = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_KILL   = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   // register map: word index taken from paddr[2]
   localparam logic CSR_IDX_END_LINE_MASK = 1'b0;
   localparam logic [BYTE_W-1:0] END_LINE_MASK_RESET = 8'h01;

   localparam logic [BYTE_W-1:0] COUNT_MAX = 8'hFF;

   typedef logic [BYTE_W-1:0] byte_type;

   function automatic logic is_blank(input byte_type c);
      return (c == 8'h20) || (c == 8'h0C) || (c == 8'h0A) || (c == 8'h0D) ||
             (c == 8'h09) || (c == 8'h0B);
   endfunction

endpackage

>>> sv/lecr_req_if.sv
// Request channel: valid/ready handshake with the request fields.
interface lecr_req_if;
   logic                          valid;
   logic                          ready;
   logic [lecr_pkg::TYPE_W-1:0]   req_type;
   lecr_pkg::byte_type            char_in;
   lecr_pkg::byte_type            flag_in;

   modport source (output valid, req_type, char_in, flag_in, input ready);
   modport sink   (input valid, req_type, char_in, flag_in, output ready);
endinterface

>>> sv/lecr_rsp_if.sv
// Response channel: valid/ready handshake with the result fields.
interface lecr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lecr_pkg::STATUS_W-1:0] status;
   lecr_pkg::byte_type            char_out;
   lecr_pkg::byte_type            flag_out;
   lecr_pkg::byte_type            erased_count;

   modport source (output valid, status, char_out, flag_out, erased_count, input ready);
   modport sink   (input valid, status, char_out, flag_out, erased_count, output ready);
endinterface

>>> sv/line_edit_char_ring_top.sv
// Line-editing character ring: two synchronous memories and a small sequencer.
// Response valid is registered from the execute state after accept; it waits while
// the previous response is not yet taken. A new request is taken only in idle. Erase
// word removes entries one by one, one memory read per removed entry, single read port.
// Synchronous active-high reset empties the ring and sets end_line_mask to 1;
// memory contents are not cleared and are never read before being written.
module line_edit_char_ring_top #(
   parameter int DEPTH = lecr_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   lecr_req_if.sink                          req,
   lecr_rsp_if.source                        rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lecr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lecr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lecr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int PW = $clog2(DEPTH);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      return (p == LAST) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PW-1:0] ptr_prev(input logic [PW-1:0] p);
      return (p == '0) ? LAST : p - 1'b1;
   endfunction

   // storage
   lecr_pkg::byte_type char_mem [DEPTH];
   lecr_pkg::byte_type flag_mem [DEPTH];

   logic                           state_ff, state_in;
   logic [PW-1:0]                  wp_ff, wp_in;
   logic [PW-1:0]                  rp_ff, rp_in;
   logic [lecr_pkg::TYPE_W-1:0]    op_ff, op_in;
   lecr_pkg::byte_type             cin_ff, cin_in;
   lecr_pkg::byte_type             fin_ff, fin_in;
   logic                           phase_ff, phase_in;
   lecr_pkg::byte_type             cnt_ff, cnt_in;
   lecr_pkg::byte_type             mask_ff, mask_in;
   lecr_pkg::byte_type             char_rd_ff, flag_rd_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [lecr_pkg::STATUS_W-1:0]  status_ff, status_in;
   lecr_pkg::byte_type             char_out_ff, char_out_in;
   lecr_pkg::byte_type             flag_out_ff, flag_out_in;
   lecr_pkg::byte_type             count_out_ff, count_out_in;

   logic                           char_we, flag_we;
   logic [PW-1:0]                  wr_addr, rd_addr;
   lecr_pkg::byte_type             char_wr, flag_wr;

   logic            accept, empty, out_free, end_mark, blank, walk_remove;
   logic [PW-1:0]   wp_prev, wp_prev2, wp_next;
   logic            csr_write;

   assign req.ready   = (state_ff == S_IDLE);
   assign accept      = req.valid & req.ready;
   assign empty       = (wp_ff == rp_ff);
   assign wp_prev     = ptr_prev(wp_ff);
   assign wp_prev2    = ptr_prev(wp_prev);
   assign wp_next     = ptr_next(wp_ff);
   assign out_free    = ~rsp_valid_ff | rsp.ready;
   assign end_mark    = |(flag_rd_ff & mask_ff);
   assign blank       = lecr_pkg::is_blank(char_rd_ff);
   // whitespace phase takes anything; the word phase stops at whitespace
   assign walk_remove = ~empty & ~end_mark & ~(~phase_ff & blank);

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = status_ff;
   assign rsp.char_out     = char_out_ff;
   assign rsp.flag_out     = flag_out_ff;
   assign rsp.erased_count = count_out_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite &
                       (csr_paddr[2] == lecr_pkg::CSR_IDX_END_LINE_MASK);
   assign mask_in    = csr_write ? csr_pwdata[lecr_pkg::BYTE_W-1:0] : mask_ff;
   assign csr_prdata = (csr_paddr[2] == lecr_pkg::CSR_IDX_END_LINE_MASK) ?
                       {{(lecr_pkg::CSR_DATA_W - lecr_pkg::BYTE_W){1'b0}}, mask_ff} : '0;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      op_in        = op_ff;
      cin_in       = cin_ff;
      fin_in       = fin_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      status_in    = status_ff;
      char_out_in  = char_out_ff;
      flag_out_in  = flag_out_ff;
      count_out_in = count_out_ff;
      char_we      = 1'b0;
      flag_we      = 1'b0;
      wr_addr      = wp_ff;
      char_wr      = cin_ff;
      flag_wr      = '0;
      rd_addr      = (op_ff == lecr_pkg::REQ_GET) ? rp_ff : wp_prev;

      unique case (state_ff)
         S_IDLE: begin
            rd_addr = (req.req_type == lecr_pkg::REQ_GET) ? rp_ff : wp_prev;
            if (accept) begin
               op_in    = req.req_type;
               cin_in   = req.char_in;
               fin_in   = req.flag_in;
               phase_in = 1'b1;
               cnt_in   = '0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (op_ff == lecr_pkg::REQ_WERASE && walk_remove) begin
               // drop one trailing entry and fetch the one before it
               wp_in    = wp_prev;
               rd_addr  = wp_prev2;
               phase_in = phase_ff & blank;
               cnt_in   = (cnt_ff == lecr_pkg::COUNT_MAX) ? cnt_ff : cnt_ff + 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               status_in    = lecr_pkg::STAT_OK;
               char_out_in  = '0;
               flag_out_in  = '0;
               count_out_in = '0;
               unique case (op_ff)
                  lecr_pkg::REQ_PUT: begin
                     if (wp_next == rp_ff) begin
                        status_in = lecr_pkg::STAT_FULL;
                     end else begin
                        char_we = 1'b1;
                        flag_we = 1'b1;
                        wp_in   = wp_next;
                     end
                  end
                  lecr_pkg::REQ_GET: begin
                     if (empty) begin
                        status_in = lecr_pkg::STAT_EMPTY;
                     end else begin
                        char_out_in = char_rd_ff;
                        flag_out_in = flag_rd_ff;
                        rp_in       = ptr_next(rp_ff);
                     end
                  end
                  lecr_pkg::REQ_MARK: begin
                     if (empty) begin
                        status_in = lecr_pkg::STAT_EMPTY;
                     end else begin
                        flag_we = 1'b1;
                        wr_addr = wp_prev;
                        flag_wr = flag_rd_ff | fin_ff;
                     end
                  end
                  lecr_pkg::REQ_ERASE: begin
                     if (empty) begin
                        status_in = lecr_pkg::STAT_EMPTY;
                     end else if (!end_mark) begin
                        wp_in = wp_prev;
                     end
                  end
                  lecr_pkg::REQ_WERASE: begin
                     // nothing removed and nothing left: the ring was empty
                     if (empty && cnt_ff == '0) begin
                        status_in = lecr_pkg::STAT_EMPTY;
                     end
                     count_out_in = cnt_ff;
                  end
                  lecr_pkg::REQ_KILL: begin
                     wp_in = '0;
                     rp_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         mask_ff      <= lecr_pkg::END_LINE_MASK_RESET;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         rsp_valid_ff <= rsp_valid_in;
         mask_ff      <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      cin_ff       <= cin_in;
      fin_ff       <= fin_in;
      phase_ff     <= phase_in;
      cnt_ff       <= cnt_in;
      status_ff    <= status_in;
      char_out_ff  <= char_out_in;
      flag_out_ff  <= flag_out_in;
      count_out_ff <= count_out_in;
   end

   always_ff @(posedge clock) begin
      if (char_we) begin
         char_mem[wr_addr] <= char_wr;
      end
      char_rd_ff <= char_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (flag_we) begin
         flag_mem[wr_addr] <= flag_wr;
      end
      flag_rd_ff <= flag_mem[rd_addr];
   end

endmodule
